// File: rtl/core/midi_track_event_parser_top_assert.svh
// Assertion macros used by the MIDI track parser checker.
`ifndef MIDI_TRACK_EVENT_PARSER_TOP_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_TOP_ASSERT_SVH

// Clocked assertion, quiet while reset is held.
`define MTEP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also checks through reset.
`define MTEP_ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/mtep_pkg.sv
// Shared types and constants of the MIDI track event parser.
`default_nettype none

package mtep_pkg;

  // Event kinds on the result channel
  localparam logic [1:0] KIND_NOTE_ON   = 2'd0;
  localparam logic [1:0] KIND_NOTE_OFF  = 2'd1;
  localparam logic [1:0] KIND_TEMPO     = 2'd2;
  localparam logic [1:0] KIND_TRACK_END = 2'd3;

  // Track-end status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_LONG      = 2'd1;
  localparam logic [1:0] STAT_NO_RUN    = 2'd2;
  localparam logic [1:0] STAT_TRUNCATED = 2'd3;

  // Byte values of the track format
  localparam logic [7:0] SYS_STATUS    = 8'hF0;
  localparam logic [7:0] SYSEX_START   = 8'hF0;
  localparam logic [7:0] SYSEX_END     = 8'hF7;
  localparam logic [7:0] META_STATUS   = 8'hFF;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [7:0] CH_NOTE_OFF   = 8'h80;
  localparam logic [7:0] CH_NOTE_ON    = 8'h90;
  localparam logic [7:0] CH_PROGRAM    = 8'hC0;
  localparam logic [7:0] CH_PRESSURE   = 8'hD0;

  // Default depth of the result queue
  localparam int OUT_DEPTH = 4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tick;
    logic [7:0]  note;
    logic [7:0]  vel;
    logic [23:0] tempo;
    logic [1:0]  status;
    logic        last;
  } result_t;

  // Results handed from the parser to the queue in the same cycle
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

`default_nettype wire

// File: rtl/core/mtep_ifs.sv
// Handshake interfaces of the byte and result channels.
`default_nettype none

interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [31:0] event_tick;
  logic [7:0]  note_number;
  logic [7:0]  note_velocity;
  logic [23:0] tempo_value;
  logic [1:0]  track_status;
  logic        last_of_run;

  modport source (output valid, output event_kind, output event_tick, output note_number,
                  output note_velocity, output tempo_value, output track_status,
                  output last_of_run, input ready);
  modport sink (input valid, input event_kind, input event_tick, input note_number,
                input note_velocity, input tempo_value, input track_status,
                input last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/core/midi_track_event_parser_top.sv
// Top level of the MIDI track event parser.
// Usage:
//   in_bus takes the body of one track chunk, one byte a beat, with last_byte
//   set on the final byte. out_bus gives note-on, note-off and set-tempo
//   events with their tick, and one track-end beat with a status at the last
//   byte; last_of_run marks the final result beat caused by a byte.
//   A result passes through the byte register and then the result queue
//   before it is offered on out_bus.
//   Throughput: one byte a cycle while out_bus drains; a byte that causes two
//   results needs two out_bus beats, so sustained output is one result beat a
//   cycle, set by the single read port of the result queue.
//   Stall: while out_ready is low the queue holds its results; in_ready drops
//   once the queue cannot take two more results and the byte register is full.
//   Reset (rst_n low, synchronous) empties the queue and the byte register and
//   returns the parse state to waiting for a delta time. The state also
//   returns there after every last byte, so the next track follows directly.
`default_nettype none

module midi_track_event_parser_top #(
  parameter int QueueDepth = mtep_pkg::OUT_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  mtep_in_if.sink       in_bus,
  mtep_out_if.source    out_bus
);

  logic              room;
  mtep_pkg::push_t   push;
  mtep_pkg::result_t out_res;

  mtep_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_bus.valid),
    .in_data_byte (in_bus.data_byte),
    .in_last_byte (in_bus.last_byte),
    .in_ready     (in_bus.ready),
    .room         (room),
    .push         (push)
  );

  mtep_out_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_res   (out_res)
  );

  // Spread the head result over the channel fields
  assign out_bus.event_kind    = out_res.kind;
  assign out_bus.event_tick    = out_res.tick;
  assign out_bus.note_number   = out_res.note;
  assign out_bus.note_velocity = out_res.vel;
  assign out_bus.tempo_value   = out_res.tempo;
  assign out_bus.track_status  = out_res.status;
  assign out_bus.last_of_run   = out_res.last;

endmodule

`default_nettype wire

// File: rtl/core/mtep_parser.sv
// Input byte register and per-byte parse state update of the MIDI track parser.
`default_nettype none

module mtep_parser (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [7:0]     in_data_byte,
  input  wire logic           in_last_byte,
  output logic                in_ready,
  input  wire logic           room,
  output mtep_pkg::push_t     push
);

  localparam logic [3:0] PH_DELTA     = 4'd0;
  localparam logic [3:0] PH_STATUS    = 4'd1;
  localparam logic [3:0] PH_DATA1     = 4'd2;
  localparam logic [3:0] PH_DATA2     = 4'd3;
  localparam logic [3:0] PH_META_TYPE = 4'd4;
  localparam logic [3:0] PH_META_LEN  = 4'd5;
  localparam logic [3:0] PH_SYSEX_LEN = 4'd6;
  localparam logic [3:0] PH_SKIP      = 4'd7;
  localparam logic [3:0] PH_ERR_LONG  = 4'd8;
  localparam logic [3:0] PH_ERR_NORUN = 4'd9;

  typedef struct packed {
    logic [3:0]  phase;
    logic [31:0] tick;
    logic [27:0] vl_acc;
    logic [1:0]  vl_bytes;
    logic [7:0]  run_st;
    logic [7:0]  cur_st;
    logic [7:0]  first;
    logic [7:0]  meta;
    logic [27:0] left;
    logic [23:0] tempo;
    logic        is_tempo;
  } pstate_t;

  localparam pstate_t PST_RESET = '{phase: PH_DELTA, default: '0};

  // Program change and channel pressure carry a single data byte
  function automatic logic one_data(input logic [7:0] st);
    return (st[7:4] == mtep_pkg::CH_PROGRAM[7:4]) || (st[7:4] == mtep_pkg::CH_PRESSURE[7:4]);
  endfunction

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       accept;
  logic       fire;

  pstate_t st_r, st_nxt, upd;

  logic [27:0] vl_acc;
  logic        vl_long;
  logic [27:0] left_dec;
  logic        ev_valid;
  logic [1:0]  ev_kind;
  logic [7:0]  ev_note;
  logic [7:0]  ev_vel;
  logic [23:0] ev_tempo;
  logic [1:0]  end_status;
  mtep_pkg::result_t ev_res, end_res;

  // Hold one byte; refill it in the cycle it moves on
  assign fire     = s1_valid_r & room;
  assign in_ready = ~s1_valid_r | room;
  assign accept   = in_valid & in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // Shift the next seven bits into a variable-length quantity
  assign vl_acc   = {st_r.vl_acc[20:0], s1_byte_r[6:0]};
  assign vl_long  = s1_byte_r[7] & (st_r.vl_bytes == 2'd3);
  assign left_dec = st_r.left - 28'd1;

  // Advance the parse state by one byte
  always_comb begin
    upd      = st_r;
    ev_valid = 1'b0;
    ev_kind  = mtep_pkg::KIND_NOTE_ON;
    ev_note  = '0;
    ev_vel   = '0;
    ev_tempo = '0;
    unique case (st_r.phase)
      PH_STATUS: begin
        if (!s1_byte_r[7]) begin
          if (st_r.run_st == '0) begin
            upd.phase = PH_ERR_NORUN;
          end else begin
            upd.cur_st = st_r.run_st;
            upd.first  = s1_byte_r;
            upd.phase  = one_data(st_r.run_st) ? PH_DELTA : PH_DATA2;
          end
        end else begin
          if (s1_byte_r < mtep_pkg::SYS_STATUS) begin
            upd.run_st = s1_byte_r;
          end
          upd.cur_st = s1_byte_r;
          if (s1_byte_r == mtep_pkg::META_STATUS) begin
            upd.phase = PH_META_TYPE;
          end else if (s1_byte_r == mtep_pkg::SYSEX_START ||
                       s1_byte_r == mtep_pkg::SYSEX_END) begin
            upd.phase = PH_SYSEX_LEN;
          end else begin
            upd.phase = PH_DATA1;
          end
        end
      end
      PH_DATA1: begin
        upd.first = s1_byte_r;
        upd.phase = one_data(st_r.cur_st) ? PH_DELTA : PH_DATA2;
      end
      PH_DATA2: begin
        ev_note = st_r.first;
        ev_vel  = s1_byte_r;
        if (st_r.cur_st[7:4] == mtep_pkg::CH_NOTE_ON[7:4] && s1_byte_r != '0) begin
          ev_valid = 1'b1;
          ev_kind  = mtep_pkg::KIND_NOTE_ON;
        end else if (st_r.cur_st[7:4] == mtep_pkg::CH_NOTE_ON[7:4] ||
                     st_r.cur_st[7:4] == mtep_pkg::CH_NOTE_OFF[7:4]) begin
          ev_valid = 1'b1;
          ev_kind  = mtep_pkg::KIND_NOTE_OFF;
        end
        upd.phase = PH_DELTA;
      end
      PH_META_TYPE: begin
        upd.meta  = s1_byte_r;
        upd.phase = PH_META_LEN;
      end
      PH_META_LEN, PH_SYSEX_LEN: begin
        upd.vl_acc = vl_acc;
        if (!s1_byte_r[7]) begin
          upd.vl_bytes = 2'd0;
          upd.left     = vl_acc;
          upd.is_tempo = (st_r.phase == PH_META_LEN) && (st_r.meta == mtep_pkg::META_TEMPO) &&
                         (vl_acc == 28'd3);
          upd.tempo    = '0;
          upd.vl_acc   = '0;
          upd.phase    = (vl_acc != '0) ? PH_SKIP : PH_DELTA;
        end else if (vl_long) begin
          upd.phase = PH_ERR_LONG;
        end else begin
          upd.vl_bytes = st_r.vl_bytes + 2'd1;
        end
      end
      PH_SKIP: begin
        upd.tempo = {st_r.tempo[15:0], s1_byte_r};
        upd.left  = left_dec;
        ev_tempo  = {st_r.tempo[15:0], s1_byte_r};
        ev_kind   = mtep_pkg::KIND_TEMPO;
        if (left_dec == '0) begin
          ev_valid  = st_r.is_tempo;
          upd.phase = PH_DELTA;
        end
      end
      PH_ERR_LONG, PH_ERR_NORUN: begin
      end
      default: begin
        upd.vl_acc = vl_acc;
        if (!s1_byte_r[7]) begin
          upd.vl_bytes = 2'd0;
          upd.tick     = st_r.tick + {4'd0, vl_acc};
          upd.vl_acc   = '0;
          upd.phase    = PH_STATUS;
        end else if (vl_long) begin
          upd.phase = PH_ERR_LONG;
        end else begin
          upd.vl_bytes = st_r.vl_bytes + 2'd1;
        end
      end
    endcase
  end

  // Grade the track at its last byte
  always_comb begin
    priority if (upd.phase == PH_ERR_LONG) begin
      end_status = mtep_pkg::STAT_LONG;
    end else if (upd.phase == PH_ERR_NORUN) begin
      end_status = mtep_pkg::STAT_NO_RUN;
    end else if (upd.phase == PH_DELTA && upd.vl_bytes == 2'd0) begin
      end_status = mtep_pkg::STAT_OK;
    end else begin
      end_status = mtep_pkg::STAT_TRUNCATED;
    end
  end

  // Build the results of this byte
  always_comb begin
    ev_res        = '0;
    ev_res.kind   = ev_kind;
    ev_res.tick   = upd.tick;
    ev_res.note   = (ev_kind == mtep_pkg::KIND_TEMPO) ? 8'd0 : ev_note;
    ev_res.vel    = (ev_kind == mtep_pkg::KIND_TEMPO) ? 8'd0 : ev_vel;
    ev_res.tempo  = (ev_kind == mtep_pkg::KIND_TEMPO) ? ev_tempo : 24'd0;
    ev_res.last   = ~s1_last_r;

    end_res        = '0;
    end_res.kind   = mtep_pkg::KIND_TRACK_END;
    end_res.tick   = upd.tick;
    end_res.status = end_status;
    end_res.last   = 1'b1;

    push.res0 = ev_valid ? ev_res : end_res;
    push.res1 = end_res;
    push.cnt  = fire ? ({1'b0, ev_valid} + {1'b0, s1_last_r}) : 2'd0;
  end

  // Commit the state; a last byte returns it to reset
  always_comb begin
    st_nxt = st_r;
    if (fire) begin
      st_nxt = s1_last_r ? PST_RESET : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PST_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mtep_out_queue.sv
// Small result queue that parts the parser from the result channel.
`default_nettype none

module mtep_out_queue #(
  parameter int Depth = mtep_pkg::OUT_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mtep_pkg::push_t   push,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mtep_pkg::result_t      out_res
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LAST_PTR = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] ROOM_MAX = CntW'(Depth - 2);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  mtep_pkg::result_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [PtrW-1:0] wr_ptr_1;
  logic            pop;

  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign room      = (count_r <= ROOM_MAX);
  assign pop       = out_valid & out_ready;
  assign wr_ptr_1  = ptr_inc(wr_ptr_r);

  // Advance pointers and the fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push.cnt == 2'd1) begin
      wr_ptr_nxt = wr_ptr_1;
    end else if (push.cnt == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_1);
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CntW'(push.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store up to two results a cycle
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_1] <= push.res1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mtep_checker.sv
// Port-level checks of the MIDI track event parser and their bind.
`default_nettype none
`include "midi_track_event_parser_top_assert.svh"

module mtep_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_event_kind,
  input wire logic [7:0]  out_note_number,
  input wire logic [7:0]  out_note_velocity,
  input wire logic [23:0] out_tempo_value,
  input wire logic [1:0]  out_track_status,
  input wire logic        out_last_of_run
);

  logic is_end;
  logic is_tempo;
  logic is_note;
  logic note_clean;
  logic fields_clean;
  logic no_tempo;

  // Classify the head beat
  assign is_end       = (out_event_kind == mtep_pkg::KIND_TRACK_END);
  assign is_tempo     = (out_event_kind == mtep_pkg::KIND_TEMPO);
  assign is_note      = (out_event_kind == mtep_pkg::KIND_NOTE_ON) ||
                        (out_event_kind == mtep_pkg::KIND_NOTE_OFF);
  assign note_clean   = (out_note_number == 8'd0) && (out_note_velocity == 8'd0);
  assign fields_clean = (out_track_status == mtep_pkg::STAT_OK) && (!is_tempo || note_clean);
  assign no_tempo     = (out_tempo_value == 24'd0);

  // Nothing leaves the queue right after reset
  `MTEP_ASSERT_ANY(a_idle_after_reset, clk, !rst_n |=> !out_valid, "result after reset")

  // A stalled result beat stays offered
  `MTEP_ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "dropped")

  // Track end is always the final beat of its byte
  `MTEP_ASSERT_CLK(a_end_last, clk, rst_n, out_valid && is_end |-> out_last_of_run, "end not last")

  // Only a track end carries a status; a tempo beat carries no note
  `MTEP_ASSERT_CLK(a_fields_clean, clk, rst_n, out_valid && !is_end |-> fields_clean, "stray field")

  // Note beats carry no tempo
  `MTEP_ASSERT_CLK(a_note_tempo, clk, rst_n, out_valid && is_note |-> no_tempo, "tempo on note")

endmodule

bind midi_track_event_parser_top mtep_checker u_mtep_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .out_event_kind    (out_bus.event_kind),
  .out_note_number   (out_bus.note_number),
  .out_note_velocity (out_bus.note_velocity),
  .out_tempo_value   (out_bus.tempo_value),
  .out_track_status  (out_bus.track_status),
  .out_last_of_run   (out_bus.last_of_run)
);

`default_nettype wire
